// ===== rtl/well_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package well_pkg;

    localparam int WORD_W     = 32;
    localparam int CMD_W      = 2;
    localparam int POOL_DEPTH = 16;
    localparam int POOL_AW    = 4;
    localparam int IN_DATA_W  = 96;

    // Seed expansion multiplier and tempering mask
    localparam logic [WORD_W-1:0] MT_MULT     = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda442d24;

    // Pool taps relative to the current position
    localparam logic [POOL_AW-1:0] TAP_C    = 4'd13;
    localparam logic [POOL_AW-1:0] TAP_V    = 4'd9;
    localparam logic [POOL_AW-1:0] TAP_PREV = 4'd15;
    localparam logic [POOL_AW-1:0] POOL_LAST = 4'd15;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEED  = 2'd0,
        CMD_NEXT  = 2'd1,
        CMD_RANGE = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SMUL,
        S_SWR,
        S_ADV0,
        S_ADV1,
        S_ADV2,
        S_ADV3,
        S_ADV4,
        S_DIV,
        S_ADD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/well_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module well_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/well512_random_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// WELL512 random number generator core.
// Input stream: s_axis_tuser carries the command (seed, next, range),
// s_axis_tdata carries seed_value, range_low and range_high. Output stream:
// m_axis_tdata carries one 32-bit number for each next or range item; seed
// items give no output, and the unused command code is dropped.
// The 16-word pool sits in a single-port-write, single-port-read RAM with a
// registered read; one item is worked at a time and s_axis_tready is high
// only while the core is idle.
// A next item runs the pool states S_ADV0 to S_ADV4 and then S_OUT; a range
// item runs the same pool states, then a 32-step shift-subtract remainder
// unit, then the offset add; an empty range goes straight to S_OUT. A seed
// item keeps the core busy for fifteen multiply-then-write steps.
// After reset the core seeds itself with zero, with tready low meanwhile.
// The output register frees the input side: a new item is taken while the
// last number waits; a second result waits in the core until the receiver
// takes the first one.

module well512_random_generator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] seed_value, [63:32] range_low, [95:64] range_high
    input  wire logic [well_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  wire logic [well_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] number
    output logic      [well_pkg::WORD_W-1:0]       m_axis_tdata
);

    import well_pkg::*;

    t_state               r_state, n_state;
    logic [POOL_AW-1:0]   r_pos, n_pos;
    logic [POOL_AW-1:0]   r_idx, n_idx;
    logic [4:0]           r_cnt, n_cnt;
    logic                 r_is_range, n_is_range;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_W-1:0]    r_out_data, n_out_data;
    logic [WORD_W-1:0]    r_prev, n_prev;
    logic [WORD_W-1:0]    r_prod, n_prod;
    logic [WORD_W-1:0]    r_low, n_low;
    logic [WORD_W-1:0]    r_span, n_span;
    logic [WORD_W-1:0]    r_a, n_a;
    logic [WORD_W-1:0]    r_b, n_b;
    logic [WORD_W-1:0]    r_c, n_c;
    logic [WORD_W-1:0]    r_d, n_d;
    logic [WORD_W-1:0]    r_rem, n_rem;
    logic [WORD_W-1:0]    r_dvd, n_dvd;
    logic [WORD_W-1:0]    r_res, n_res;

    logic                 ram_wr_en;
    logic [POOL_AW-1:0]   ram_wr_addr;
    logic [WORD_W-1:0]    ram_wr_data;
    logic [POOL_AW-1:0]   ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;

    logic [WORD_W-1:0]    in_seed, in_low, in_high;

    assign in_seed = s_axis_tdata[WORD_W-1:0];
    assign in_low  = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_high = s_axis_tdata[3*WORD_W-1:2*WORD_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    well_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pos       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_is_range  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_is_range  <= n_is_range;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_prev     <= n_prev;
        r_prod     <= n_prod;
        r_low      <= n_low;
        r_span     <= n_span;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_res      <= n_res;
    end

    always_comb begin
        logic [WORD_W-1:0] seed_word;
        logic [WORD_W-1:0] c_mix;
        logic [WORD_W-1:0] a_new;
        logic [WORD_W-1:0] fin;
        logic [WORD_W:0]   trial;

        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_is_range  = r_is_range;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_prev      = r_prev;
        n_prod      = r_prod;
        n_low       = r_low;
        n_span      = r_span;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_res       = r_res;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pos;
        ram_wr_data = r_res;
        ram_rd_addr = r_pos;

        seed_word = r_prod + {{(WORD_W-POOL_AW){1'b0}}, r_idx};
        c_mix     = ram_rd_data ^ (ram_rd_data >> 11);
        a_new     = r_b ^ c_mix;
        fin       = ram_rd_data ^ r_b ^ r_d ^ (ram_rd_data << 2)
                    ^ (r_b << 18) ^ (r_c << 28);
        trial     = {r_rem, r_dvd[WORD_W-1]};

        unique case (r_state)
            S_INIT: begin
                // seed with zero after reset
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = '0;
                n_prev      = '0;
                n_idx       = POOL_AW'(1);
                n_pos       = '0;
                n_state     = S_SMUL;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        CMD_SEED: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = '0;
                            ram_wr_data = in_seed;
                            n_prev      = in_seed;
                            n_idx       = POOL_AW'(1);
                            n_pos       = '0;
                            n_state     = S_SMUL;
                        end
                        CMD_NEXT: begin
                            n_is_range = 1'b0;
                            n_state    = S_ADV0;
                        end
                        CMD_RANGE: begin
                            if (in_low == in_high) begin
                                n_res   = in_low;
                                n_state = S_OUT;
                            end else begin
                                n_is_range = 1'b1;
                                n_low      = in_low;
                                n_span     = in_high - in_low;
                                n_state    = S_ADV0;
                            end
                        end
                        default: begin
                            // drop unused command
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SMUL: begin
                n_prod  = (r_prev ^ (r_prev >> 30)) * MT_MULT;
                n_state = S_SWR;
            end
            S_SWR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx;
                ram_wr_data = seed_word;
                n_prev      = seed_word;
                n_idx       = r_idx + POOL_AW'(1);
                n_state     = (r_idx == POOL_LAST) ? S_IDLE : S_SMUL;
            end
            S_ADV0: begin
                ram_rd_addr = r_pos;
                n_state     = S_ADV1;
            end
            S_ADV1: begin
                ram_rd_addr = r_pos + TAP_C;
                n_a         = ram_rd_data;
                n_state     = S_ADV2;
            end
            S_ADV2: begin
                ram_rd_addr = r_pos + TAP_V;
                n_b         = r_a ^ ram_rd_data ^ (r_a << 16) ^ (ram_rd_data << 15);
                n_state     = S_ADV3;
            end
            S_ADV3: begin
                ram_rd_addr = r_pos + TAP_PREV;
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos;
                ram_wr_data = a_new;
                n_c         = c_mix;
                n_d         = a_new ^ ((a_new << 5) & TEMPER_MASK);
                n_state     = S_ADV4;
            end
            S_ADV4: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos + TAP_PREV;
                ram_wr_data = fin;
                n_pos       = r_pos + TAP_PREV;
                if (r_is_range) begin
                    n_dvd   = fin;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_res   = fin;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                // one remainder bit per cycle, MSB first
                if (trial >= {1'b0, r_span}) begin
                    n_rem = WORD_W'(trial - {1'b0, r_span});
                end else begin
                    n_rem = trial[WORD_W-1:0];
                end
                n_dvd   = r_dvd << 1;
                n_cnt   = r_cnt + 5'd1;
                n_state = (r_cnt == 5'd31) ? S_ADD : S_DIV;
            end
            S_ADD: begin
                n_res   = r_rem + r_low;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/well_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module well_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [well_pkg::CMD_W-1:0]     s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [well_pkg::WORD_W-1:0]    m_axis_tdata
);

    import well_pkg::*;

    // reset starts the zero-seed pass, so the input side stays closed
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // a real command makes the core busy in the cycle after it is taken
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == CMD_SEED || s_axis_tuser == CMD_NEXT ||
          s_axis_tuser == CMD_RANGE)) |=> !s_axis_tready)
        else $error("input ready right after a command item");

    // a fresh output item comes only from work in progress
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output item appeared while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output item changed");

endmodule

bind well512_random_generator_core well_chk u_well_chk (.*);

`default_nettype wire
